/* hw/rtl/clq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package clq_pkg;

	// Default geometry of the centroid store.
	localparam int CLQ_MAX_CENTROIDS = 16;
	localparam int CLQ_CHANNELS      = 3;
	localparam int CLQ_FRAC_BITS     = 16;

	// Fixed field widths.
	localparam int PIX_W      = 8;
	localparam int ALPHA_W    = 16;
	localparam int WIN_W      = 16;
	localparam int MAXC_W     = 5;
	localparam int LABEL_W    = 4;
	localparam int ACTIVE_W   = 5;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_CLUSTERS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_THRESHOLD = 2'd2;

	// Configuration reset values.
	localparam logic [ALPHA_W-1:0] LEARN_RATE_RST    = 16'd6554;
	localparam logic [MAXC_W-1:0]  MAX_CLUSTERS_RST  = 5'd8;
	localparam logic [WIN_W-1:0]   WIN_THRESHOLD_RST = 16'd1131;

	// Win counters saturate here.
	localparam logic [WIN_W-1:0] WIN_SAT = 16'hFFFF;

	// Item function codes.
	localparam logic FUNC_TRAIN    = 1'b0;
	localparam logic FUNC_CLASSIFY = 1'b1;

	typedef struct packed {
		logic [ALPHA_W-1:0] learn_rate;
		logic [MAXC_W-1:0]  max_clusters;
		logic [WIN_W-1:0]   win_threshold;
	} cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/clq_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Pixel channel: one beat carries one pixel and its function code.
interface clq_in_if;
	import clq_pkg::*;

	logic             valid;
	logic             ready;
	logic             func;
	logic [PIX_W-1:0] pixel_red;
	logic [PIX_W-1:0] pixel_green;
	logic [PIX_W-1:0] pixel_blue;

	modport source (
		output valid, func, pixel_red, pixel_green, pixel_blue,
		input  ready
	);
	modport sink (
		input  valid, func, pixel_red, pixel_green, pixel_blue,
		output ready
	);
endinterface

// Result channel: one beat carries the label and the cluster count.
interface clq_out_if;
	import clq_pkg::*;

	logic                valid;
	logic                ready;
	logic [LABEL_W-1:0]  label;
	logic [ACTIVE_W-1:0] active_clusters;

	modport source (
		output valid, label, active_clusters,
		input  ready
	);
	modport sink (
		input  valid, label, active_clusters,
		output ready
	);
endinterface

`default_nettype wire

/* hw/rtl/clq_dist.sv */
`timescale 1ns / 1ps
`default_nettype none

// Three-stage squared-distance pipeline: absolute differences, squares, sum.
module clq_dist #(
	parameter int CHANNELS  = clq_pkg::CLQ_CHANNELS,
	parameter int FRAC_BITS = clq_pkg::CLQ_FRAC_BITS,
	parameter int TAG_W     = 5
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               in_valid,
	input  logic [TAG_W-1:0]                                   in_tag,
	input  logic [CHANNELS-1:0][clq_pkg::PIX_W-1:0]            pix,
	input  logic [CHANNELS-1:0][clq_pkg::PIX_W+FRAC_BITS-1:0]  row,
	output logic                                               out_valid,
	output logic [TAG_W-1:0]                                   out_tag,
	output logic [2*(clq_pkg::PIX_W+FRAC_BITS)+1:0]            sq_dist
);
	import clq_pkg::*;

	localparam int CW     = PIX_W + FRAC_BITS;
	localparam int DIST_W = 2 * CW + 2;

	logic [CHANNELS-1:0][CW-1:0]   absd;
	logic [CHANNELS-1:0][CW-1:0]   absd_s1;
	logic [CHANNELS-1:0][2*CW-1:0] sq;
	logic [CHANNELS-1:0][2*CW-1:0] sq_s2;
	logic [DIST_W-1:0]             sum;
	logic [DIST_W-1:0]             dist_s3;
	logic                          v_s1, v_s2, v_s3;
	logic [TAG_W-1:0]              tag_s1, tag_s2, tag_s3;

	// Per-channel absolute difference against the pixel scaled to fixed point.
	always_comb begin
		logic [CW-1:0] p;
		for (int c = 0; c < CHANNELS; c++) begin
			p = {pix[c], {FRAC_BITS{1'b0}}};
			absd[c] = (p >= row[c]) ? (p - row[c]) : (row[c] - p);
		end
	end

	// One square per channel.
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			sq[c] = absd_s1[c] * absd_s1[c];
		end
	end

	// Sum of the channel squares.
	always_comb begin
		sum = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			sum = sum + DIST_W'(sq_s2[c]);
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		absd_s1 <= absd;
		sq_s2   <= sq;
		dist_s3 <= sum;
		tag_s1  <= in_tag;
		tag_s2  <= tag_s1;
		tag_s3  <= tag_s2;
	end

	// Valid bits follow the data down the pipe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_tag   = tag_s3;
	assign sq_dist   = dist_s3;

endmodule

`default_nettype wire

/* hw/rtl/competitive_learning_color_quantizer.sv */
`timescale 1ns / 1ps
`default_nettype none

// Order: a classify result follows the centroid scan and the pipeline drain; a train
// result also passes winner read, multiply and add, and a split if the winner splits.
// Throughput: one item at a time, the next pixel beat is taken the cycle after the
// result is loaded; the scan reads one centroid per cycle through the store's read port.
// Reset: centroid 0 at zero with a zero win count, one active centroid, registers at
// their defaults; no clearing pass, the block takes pixels right after reset.
module competitive_learning_color_quantizer #(
	parameter int MAX_CENTROIDS = clq_pkg::CLQ_MAX_CENTROIDS,
	parameter int CHANNELS      = clq_pkg::CLQ_CHANNELS,
	parameter int FRAC_BITS     = clq_pkg::CLQ_FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [clq_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [clq_pkg::CFG_DATA_W-1:0]   wr_data,
	clq_in_if.sink                           pixels,
	clq_out_if.source                        results
);
	import clq_pkg::*;

	localparam int CW      = PIX_W + FRAC_BITS;
	localparam int IDX_W   = $clog2(MAX_CENTROIDS);
	localparam int CNT_W   = $clog2(MAX_CENTROIDS + 1);
	localparam int CMP_W   = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;
	localparam int DIST_W  = 2 * CW + 2;
	localparam int TAG_W   = IDX_W + 1;
	localparam int PROD_W  = CW + ALPHA_W + 2;
	localparam int STEP_W  = CW + 2;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SCAN  = 4'd1;
	localparam logic [3:0] ST_DRAIN = 4'd2;
	localparam logic [3:0] ST_RDW   = 4'd3;
	localparam logic [3:0] ST_MUL   = 4'd4;
	localparam logic [3:0] ST_ADD   = 4'd5;
	localparam logic [3:0] ST_SPLIT = 4'd6;
	localparam logic [3:0] ST_DONE  = 4'd7;

	typedef logic [CHANNELS-1:0][CW-1:0] row_t;

	cfg_t                         cfg_q;
	logic [3:0]                   state_q;
	logic [IDX_W-1:0]             scan_idx_q;
	logic                         best_v_q;
	logic [IDX_W-1:0]             best_idx_q;
	logic [DIST_W-1:0]            best_dist_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         row0_q;
	logic                         func_q;
	logic [CHANNELS-1:0][PIX_W-1:0] pix_q;
	logic [CHANNELS-1:0][PIX_W-1:0] pix_in;
	logic                         out_v_q;
	logic [LABEL_W-1:0]           label_q;
	logic [ACTIVE_W-1:0]          active_q;

	// Centroid and win-count stores.
	row_t                         cent_mem [MAX_CENTROIDS];
	logic [WIN_W-1:0]             win_mem  [MAX_CENTROIDS];
	row_t                         cent_rd_q;
	logic [WIN_W-1:0]             win_rd_q;
	logic                         rd_zero_q;
	logic                         rd_v_q;
	logic [TAG_W-1:0]             rd_tag_q;
	logic [IDX_W-1:0]             rd_addr;
	row_t                         row_rd;
	logic [WIN_W-1:0]             win_rd;
	logic                         mem_we;
	logic [IDX_W-1:0]             mem_waddr;
	row_t                         mem_wrow;
	logic [WIN_W-1:0]             mem_wwin;

	// Distance pipeline outputs.
	logic                         d_v;
	logic [TAG_W-1:0]             d_tag;
	logic [DIST_W-1:0]            d_dist;
	logic                         d_last;
	logic                         upd_best;

	// Update datapath.
	logic [CHANNELS-1:0][STEP_W-1:0] step;
	logic [CHANNELS-1:0][STEP_W-1:0] step_q;
	row_t                         cur_q;
	row_t                         new_row;
	row_t                         new_row_q;
	logic [WIN_W-1:0]             wc_bump;
	logic [WIN_W-1:0]             wc_q;
	logic [CMP_W-1:0]             lim;
	logic                         split;

	logic                         in_acc;
	logic                         out_load;
	logic                         scan_last;
	logic [IDX_W+LABEL_W-1:0]     lbl_ext;
	logic [CNT_W+ACTIVE_W-1:0]    act_ext;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.learn_rate    <= LEARN_RATE_RST;
			cfg_q.max_clusters  <= MAX_CLUSTERS_RST;
			cfg_q.win_threshold <= WIN_THRESHOLD_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_LEARN_RATE:    cfg_q.learn_rate    <= wr_data[ALPHA_W-1:0];
				REG_MAX_CLUSTERS:  cfg_q.max_clusters  <= wr_data[MAXC_W-1:0];
				REG_WIN_THRESHOLD: cfg_q.win_threshold <= wr_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Pixel fields mapped onto channels; missing channels read as zero.
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			if (c == 0) begin
				pix_in[c] = pixels.pixel_red;
			end else if (c == 1) begin
				pix_in[c] = pixels.pixel_green;
			end else if (c == 2) begin
				pix_in[c] = pixels.pixel_blue;
			end else begin
				pix_in[c] = '0;
			end
		end
	end

	assign pixels.ready = (state_q == ST_IDLE);
	assign in_acc       = pixels.valid && pixels.ready;
	assign out_load     = (state_q == ST_DONE) && (!out_v_q || results.ready);
	assign scan_last    = (CNT_W'(scan_idx_q) + CNT_W'(1)) == cnt_q;
	assign rd_addr      = (state_q == ST_SCAN) ? scan_idx_q : best_idx_q;

	// Store reads, registered.
	always_ff @(posedge clk) begin
		cent_rd_q <= cent_mem[rd_addr];
		win_rd_q  <= win_mem[rd_addr];
		rd_zero_q <= (rd_addr == '0);
		rd_tag_q  <= {scan_last, scan_idx_q};
	end

	// Store writes.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			cent_mem[mem_waddr] <= mem_wrow;
			win_mem[mem_waddr]  <= mem_wwin;
		end
	end

	// Entry 0 reads as zero until its first write-back.
	assign row_rd = (rd_zero_q && !row0_q) ? '0 : cent_rd_q;
	assign win_rd = (rd_zero_q && !row0_q) ? '0 : win_rd_q;

	clq_dist #(
		.CHANNELS  (CHANNELS),
		.FRAC_BITS (FRAC_BITS),
		.TAG_W     (TAG_W)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rd_v_q),
		.in_tag    (rd_tag_q),
		.pix       (pix_q),
		.row       (row_rd),
		.out_valid (d_v),
		.out_tag   (d_tag),
		.sq_dist   (d_dist)
	);

	assign d_last   = d_tag[IDX_W];
	assign upd_best = d_v && (!best_v_q || (d_dist < best_dist_q));

	// Step toward the pixel: floor(alpha * (pixel - centroid)).
	always_comb begin
		logic signed [CW:0]       diff;
		logic signed [PROD_W-1:0] prod;
		for (int c = 0; c < CHANNELS; c++) begin
			diff = $signed({1'b0, pix_q[c], {FRAC_BITS{1'b0}}}) - $signed({1'b0, row_rd[c]});
			prod = diff * $signed({1'b0, cfg_q.learn_rate});
			step[c] = prod[PROD_W-1:ALPHA_W];
		end
	end

	// Moved centroid; it stays within range, so truncation is exact.
	always_comb begin
		logic [STEP_W-1:0] sum;
		for (int c = 0; c < CHANNELS; c++) begin
			sum = {2'b00, cur_q[c]} + step_q[c];
			new_row[c] = sum[CW-1:0];
		end
	end

	assign wc_bump = (win_rd == WIN_SAT) ? win_rd : (win_rd + WIN_W'(1));
	assign lim     = (CMP_W'(cfg_q.max_clusters) > CMP_W'(MAX_CENTROIDS))
	               ? CMP_W'(MAX_CENTROIDS) : CMP_W'(cfg_q.max_clusters);
	assign split   = (wc_q == cfg_q.win_threshold) && (CMP_W'(cnt_q) < lim);

	// Write-back of the winner, then of the split copy.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = best_idx_q;
		mem_wrow  = new_row;
		mem_wwin  = split ? '0 : wc_q;
		case (state_q)
			ST_ADD: begin
				mem_we = 1'b1;
			end
			ST_SPLIT: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q[IDX_W-1:0];
				mem_wrow  = new_row_q;
				mem_wwin  = '0;
			end
			default: ;
		endcase
	end

	// Update datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			step_q <= step;
			cur_q  <= row_rd;
			wc_q   <= wc_bump;
		end
		if (state_q == ST_ADD) begin
			new_row_q <= new_row;
		end
		if (in_acc) begin
			pix_q  <= pix_in;
			func_q <= pixels.func;
		end
		if (upd_best) begin
			best_dist_q <= d_dist;
		end
	end

	assign lbl_ext = {{LABEL_W{1'b0}}, best_idx_q};
	assign act_ext = {{ACTIVE_W{1'b0}}, cnt_q};

	// Sequencer: scan, drain, read winner, multiply, add and write, split, deliver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_idx_q <= '0;
			best_v_q   <= 1'b0;
			best_idx_q <= '0;
			cnt_q      <= CNT_W'(1);
			row0_q     <= 1'b0;
			rd_v_q     <= 1'b0;
			out_v_q    <= 1'b0;
			label_q    <= '0;
			active_q   <= '0;
		end else begin
			rd_v_q <= (state_q == ST_SCAN);
			if (upd_best) begin
				best_v_q   <= 1'b1;
				best_idx_q <= d_tag[IDX_W-1:0];
			end
			if (out_load) begin
				out_v_q  <= 1'b1;
				label_q  <= lbl_ext[LABEL_W-1:0];
				active_q <= act_ext[ACTIVE_W-1:0];
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						scan_idx_q <= '0;
						best_v_q   <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + IDX_W'(1);
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (d_v && d_last) begin
						state_q <= (func_q == FUNC_TRAIN) ? ST_RDW : ST_DONE;
					end
				end
				ST_RDW: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (best_idx_q == '0) begin
						row0_q <= 1'b1;
					end
					state_q <= split ? ST_SPLIT : ST_DONE;
				end
				ST_SPLIT: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign results.valid           = out_v_q;
	assign results.label           = label_q;
	assign results.active_clusters = active_q;

endmodule

`default_nettype wire

/* hw/rtl/clq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks on the quantizer.
module clq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [clq_pkg::LABEL_W-1:0]   label,
	input logic [clq_pkg::ACTIVE_W-1:0]  active
);
	import clq_pkg::*;

	logic [1:0] pending_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// Items taken whose results are not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else if (in_beat && !out_beat) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_beat && !in_beat) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(label) && $stable(active))
		else $error("result changed while stalled");

	// The winner is always one of the active centroids.
	a_label_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, label} < active)
		else $error("label beyond active clusters");

	// Cluster count stays within one and sixteen.
	a_active_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (active >= 5'd1) && (active <= 5'd16))
		else $error("active cluster count out of range");

	// No result without an item behind it.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result without a pending item");

	// At most one item in work beside one waiting result.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |-> pending_q <= 2'd1)
		else $error("pixel taken with two items outstanding");

endmodule

bind competitive_learning_color_quantizer clq_checker u_clq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixels.valid),
	.in_ready  (pixels.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.label     (results.label),
	.active    (results.active_clusters)
);

`default_nettype wire
